[design/lsc_pkg.sv]
// Shared types, codes and constants of the launch sequencer.
package lsc_pkg;

  localparam int unsigned THRUSTER_COUNT_DEF = 3;

  localparam int unsigned TIME_W  = 32;
  localparam int unsigned GAP_W   = 20;
  localparam int unsigned PCT_W   = 7;
  localparam int unsigned CODE_W  = 14;
  localparam int unsigned REQ_W   = 3;
  localparam int unsigned MODE_W  = 3;
  localparam int unsigned MASK_W  = 3;
  localparam int unsigned CIDX_W  = 3;

  localparam logic [TIME_W-1:0] ADVANCE_STEP_US = 32'd1000000;

  // request codes on the input channel
  localparam logic [REQ_W-1:0] REQ_TICK    = 3'd0;
  localparam logic [REQ_W-1:0] REQ_ESCAPE  = 3'd1;
  localparam logic [REQ_W-1:0] REQ_SELECT  = 3'd2;
  localparam logic [REQ_W-1:0] REQ_SUBMIT  = 3'd3;
  localparam logic [REQ_W-1:0] REQ_ADVANCE = 3'd4;
  localparam logic [REQ_W-1:0] REQ_RSVD5   = 3'd5;
  localparam logic [REQ_W-1:0] REQ_RSVD6   = 3'd6;
  localparam logic [REQ_W-1:0] REQ_RSVD7   = 3'd7;

  // mode codes
  localparam logic [MODE_W-1:0] MODE_HIDDEN = 3'd0;
  localparam logic [MODE_W-1:0] MODE_ENTER  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_WRONG  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_COUNT  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_LAUNCH = 3'd4;
  localparam logic [MODE_W-1:0] MODE_DONE   = 3'd5;

  // configuration register indexes
  localparam logic [CIDX_W-1:0] CFG_COUNTDOWN = 3'd0;
  localparam logic [CIDX_W-1:0] CFG_LAUNCH    = 3'd1;
  localparam logic [CIDX_W-1:0] CFG_WRONG     = 3'd2;
  localparam logic [CIDX_W-1:0] CFG_LEAD      = 3'd3;
  localparam logic [CIDX_W-1:0] CFG_START     = 3'd4;
  localparam logic [CIDX_W-1:0] CFG_FLOOR     = 3'd5;
  localparam logic [CIDX_W-1:0] CFG_ON        = 3'd6;
  localparam logic [CIDX_W-1:0] CFG_SPEEDUP   = 3'd7;

  // configuration reset values
  localparam logic [TIME_W-1:0] COUNTDOWN_RST = 32'd20500000;
  localparam logic [TIME_W-1:0] LAUNCH_RST    = 32'd10000000;
  localparam logic [TIME_W-1:0] WRONG_RST     = 32'd3000000;
  localparam logic [TIME_W-1:0] LEAD_RST      = 32'd6500000;
  localparam logic [GAP_W-1:0]  START_RST     = 20'd750000;
  localparam logic [GAP_W-1:0]  FLOOR_RST     = 20'd100000;
  localparam logic [GAP_W-1:0]  ON_RST        = 20'd150000;
  localparam logic [PCT_W-1:0]  SPEEDUP_RST   = 7'd12;
  localparam logic [PCT_W-1:0]  PCT_MAX       = 7'd100;

  // gap * pct / 100 by reciprocal: exact for every product below 2^27
  localparam int unsigned PROD_W       = GAP_W + PCT_W;
  localparam int unsigned RECIP_SHIFT  = 34;
  localparam int unsigned RECIP_W      = 28;
  localparam logic [RECIP_W-1:0] RECIP_MUL = 28'd171798692;
  localparam int unsigned RPROD_W      = PROD_W + RECIP_W;

  // cycles from a gap change until the next gap is ready
  localparam int unsigned GAP_LAT = 3;
  localparam int unsigned BUSY_W  = 2;

  localparam int unsigned QUEUE_DEPTH = 2;

  typedef enum logic [2:0] {
    OP_TICK,
    OP_ESCAPE,
    OP_SELECT,
    OP_SUBMIT,
    OP_ADVANCE,
    OP_NONE
  } op_e;

  // one classified word in the queue, with the deadlines it may need
  typedef struct packed {
    op_e               op;
    logic [TIME_W-1:0] now_us;
    logic [CODE_W-1:0] code;
    logic              frac;
    logic [TIME_W-1:0] dl_on;
    logic [TIME_W-1:0] dl_wrong;
    logic [TIME_W-1:0] dl_count;
    logic [TIME_W-1:0] dl_first;
    logic [TIME_W-1:0] dl_launch;
  } item_t;

  // configuration the back end reads directly
  typedef struct packed {
    logic [GAP_W-1:0] start;
    logic [GAP_W-1:0] floor;
    logic [PCT_W-1:0] pct;
    logic             wr;
  } cfg_t;

  function automatic logic is_past(input logic [TIME_W-1:0] t, input logic [TIME_W-1:0] d);
    logic [TIME_W-1:0] diff;
    diff = t - d;
    return (diff != '0) && !diff[TIME_W-1];
  endfunction

endpackage

[design/lsc_if.sv]
// Channel interfaces: request, result and configuration write.
interface lsc_req_if import lsc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [REQ_W-1:0]  req_type;
  logic [TIME_W-1:0] now_us;
  logic [CODE_W-1:0] entry_code;
  logic              has_fraction;

  modport source(output valid, req_type, now_us, entry_code, has_fraction, input ready);
  modport sink(input valid, req_type, now_us, entry_code, has_fraction, output ready);
endinterface

interface lsc_rsp_if import lsc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [MASK_W-1:0] thruster_mask;
  logic              booster_on;
  logic              joystick_muted;

  modport source(output valid, mode, thruster_mask, booster_on, joystick_muted, input ready);
  modport sink(input valid, mode, thruster_mask, booster_on, joystick_muted, output ready);
endinterface

interface lsc_cfg_if import lsc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CIDX_W-1:0] index;
  logic [TIME_W-1:0] data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

[design/lsc_front.sv]
// Front end: configuration registers, request decode and deadline precompute.
module lsc_front import lsc_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  lsc_req_if.sink req_i,
  lsc_cfg_if.sink cfg_i,
  input  logic   q_full_i,
  output logic   q_push_o,
  output item_t  item_o,
  output cfg_t   cfg_o
);

  logic [TIME_W-1:0] countdown_q, launch_q, wrong_q, lead_q;
  logic [GAP_W-1:0]  start_q, floor_q, on_q;
  logic [PCT_W-1:0]  pct_q;
  logic              cfg_wr;
  op_e               op;

  assign cfg_i.ready = 1'b1;
  assign cfg_wr      = cfg_i.valid && cfg_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      countdown_q <= COUNTDOWN_RST;
      launch_q    <= LAUNCH_RST;
      wrong_q     <= WRONG_RST;
      lead_q      <= LEAD_RST;
      start_q     <= START_RST;
      floor_q     <= FLOOR_RST;
      on_q        <= ON_RST;
      pct_q       <= SPEEDUP_RST;
    end else if (cfg_wr) begin
      unique case (cfg_i.index)
        CFG_COUNTDOWN: countdown_q <= cfg_i.data;
        CFG_LAUNCH:    launch_q    <= cfg_i.data;
        CFG_WRONG:     wrong_q     <= cfg_i.data;
        CFG_LEAD:      lead_q      <= cfg_i.data;
        CFG_START:     start_q     <= cfg_i.data[GAP_W-1:0];
        CFG_FLOOR:     floor_q     <= cfg_i.data[GAP_W-1:0];
        CFG_ON:        on_q        <= cfg_i.data[GAP_W-1:0];
        CFG_SPEEDUP:   pct_q       <= cfg_i.data[PCT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (req_i.req_type)
      REQ_TICK:    op = OP_TICK;
      REQ_ESCAPE:  op = OP_ESCAPE;
      REQ_SELECT:  op = OP_SELECT;
      REQ_SUBMIT:  op = OP_SUBMIT;
      REQ_ADVANCE: op = OP_ADVANCE;
      REQ_RSVD5, REQ_RSVD6, REQ_RSVD7: op = OP_NONE;
      default:     op = OP_NONE;
    endcase
  end

  assign req_i.ready = !q_full_i;
  assign q_push_o    = req_i.valid && req_i.ready;

  always_comb begin
    item_o.op        = op;
    item_o.now_us    = req_i.now_us;
    item_o.code      = req_i.entry_code;
    item_o.frac      = req_i.has_fraction;
    item_o.dl_on     = req_i.now_us + TIME_W'(on_q);
    item_o.dl_wrong  = req_i.now_us + wrong_q;
    item_o.dl_count  = req_i.now_us + countdown_q;
    item_o.dl_first  = req_i.now_us + countdown_q - lead_q;
    item_o.dl_launch = req_i.now_us + launch_q;
  end

  assign cfg_o.start = start_q;
  assign cfg_o.floor = floor_q;
  assign cfg_o.pct   = pct_q;
  assign cfg_o.wr    = cfg_wr;

endmodule

[design/lsc_queue.sv]
// Short queue of classified words between front and back end.
module lsc_queue import lsc_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t item_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  valid_o,
  output item_t item_o
);

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  item_t            slot_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_q, rd_q;
  logic [CNT_W-1:0] cnt_q;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (32'(p) == QUEUE_DEPTH - 1) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= ptr_inc(wr_q);
      end
      if (pop_i) begin
        rd_q <= ptr_inc(rd_q);
      end
      cnt_q <= cnt_q + CNT_W'(push_i) - CNT_W'(pop_i);
    end
  end

  assign full_o  = (cnt_q == CNT_W'(QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign item_o  = slot_q[rd_q];

endmodule

[design/lsc_back.sv]
// Back end: mode sequencer, thruster chaser, gap pipeline and result register.
module lsc_back import lsc_pkg::*; #(
  parameter int unsigned THRUSTER_COUNT = THRUSTER_COUNT_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      q_valid_i,
  input  item_t     item_i,
  output logic      q_pop_o,
  input  cfg_t      cfg_i,
  lsc_rsp_if.source rsp_o
);

  localparam int unsigned IDX_W = (THRUSTER_COUNT > 1) ? $clog2(THRUSTER_COUNT) : 1;

  logic [MODE_W-1:0] mode_q, mode_d;
  logic [TIME_W-1:0] ev_dl_q, ev_dl_d, ch_dl_q, ch_dl_d;
  logic [CODE_W-1:0] code_q, code_d;
  logic              phase_q, phase_d;
  logic [IDX_W-1:0]  idx_q, idx_d, idx_next;
  logic [GAP_W-1:0]  period_q, period_d;
  logic [MASK_W-1:0] thr_q, thr_d;
  logic              boost_q, boost_d, mute_q, mute_d;
  logic              period_chg, ch_past, ev_past, exec;

  logic [BUSY_W-1:0] busy_q;
  logic [PCT_W-1:0]  pct_c;
  logic [PROD_W-1:0] prod_q;
  logic [RPROD_W-1:0] rprod;
  logic [GAP_W-1:0]  red_q, gap_q, gap_diff;

  logic              out_valid_q;
  logic [MODE_W-1:0] out_mode_q;
  logic [MASK_W-1:0] out_mask_q;
  logic              out_boost_q, out_mute_q;

  function automatic logic [MASK_W-1:0] thr_bit(input logic [IDX_W-1:0] idx);
    if (32'(idx) >= 32'd2) begin
      return 3'b100;
    end else if (32'(idx) == 32'd1) begin
      return 3'b010;
    end
    return 3'b001;
  endfunction

  // Next gap, worked out ahead of use: product, reciprocal, floor.
  assign pct_c    = (cfg_i.pct > PCT_MAX) ? PCT_MAX : cfg_i.pct;
  assign rprod    = RPROD_W'(prod_q) * RPROD_W'(RECIP_MUL);
  assign gap_diff = period_q - red_q;

  always_ff @(posedge clk_i) begin
    prod_q <= PROD_W'(period_q) * PROD_W'(pct_c);
    red_q  <= rprod[RECIP_SHIFT +: GAP_W];
    gap_q  <= (gap_diff < cfg_i.floor) ? cfg_i.floor : gap_diff;
  end

  // hold the queue while the gap pipeline settles or a result word waits
  assign exec     = q_valid_i && (busy_q == '0) && (!out_valid_q || rsp_o.ready);
  assign q_pop_o  = exec;
  assign idx_next = (32'(idx_q) == THRUSTER_COUNT - 1) ? '0 : idx_q + 1'b1;
  assign ch_past  = is_past(item_i.now_us, ch_dl_q);
  assign ev_past  = is_past(item_i.now_us, ev_dl_q);

  always_comb begin
    mode_d     = mode_q;
    ev_dl_d    = ev_dl_q;
    ch_dl_d    = ch_dl_q;
    code_d     = code_q;
    phase_d    = phase_q;
    idx_d      = idx_q;
    period_d   = period_q;
    thr_d      = thr_q;
    boost_d    = boost_q;
    mute_d     = mute_q;
    period_chg = 1'b0;
    unique case (item_i.op)
      OP_TICK: begin
        if ((mode_q == MODE_COUNT || mode_q == MODE_LAUNCH) && ch_past) begin
          mute_d = 1'b1;
          if (!phase_q) begin
            thr_d   = thr_q | thr_bit(idx_q);
            phase_d = 1'b1;
            ch_dl_d = item_i.dl_on;
          end else begin
            thr_d      = thr_q & ~thr_bit(idx_q);
            phase_d    = 1'b0;
            idx_d      = idx_next;
            period_d   = gap_q;
            ch_dl_d    = item_i.now_us + TIME_W'(gap_q);
            period_chg = 1'b1;
          end
        end
        if (ev_past) begin
          unique case (mode_q)
            MODE_WRONG: begin
              mode_d  = MODE_ENTER;
              boost_d = 1'b0;
            end
            MODE_COUNT: begin
              mode_d  = MODE_LAUNCH;
              boost_d = 1'b1;
              ev_dl_d = item_i.dl_launch;
            end
            MODE_LAUNCH: begin
              mode_d  = MODE_DONE;
              thr_d   = '0;
              mute_d  = 1'b0;
              boost_d = 1'b0;
            end
            default: ;
          endcase
        end
      end
      OP_ESCAPE: begin
        if (mode_q != MODE_HIDDEN) begin
          mode_d  = MODE_HIDDEN;
          boost_d = 1'b0;
          code_d  = '0;
        end
      end
      OP_SELECT: begin
        if (mode_q == MODE_HIDDEN) begin
          code_d  = item_i.code;
          mode_d  = MODE_ENTER;
          boost_d = 1'b0;
        end
      end
      OP_SUBMIT: begin
        if (mode_q == MODE_ENTER) begin
          boost_d = 1'b0;
          if (item_i.code == code_q && !item_i.frac) begin
            mode_d     = MODE_COUNT;
            ev_dl_d    = item_i.dl_count;
            phase_d    = 1'b0;
            idx_d      = '0;
            period_d   = cfg_i.start;
            ch_dl_d    = item_i.dl_first;
            period_chg = 1'b1;
          end else begin
            mode_d  = MODE_WRONG;
            ev_dl_d = item_i.dl_wrong;
          end
        end
      end
      OP_ADVANCE: begin
        if (mode_q == MODE_WRONG || mode_q == MODE_COUNT) begin
          ev_dl_d = ev_dl_q - ADVANCE_STEP_US;
        end
      end
      OP_NONE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_HIDDEN;
      ev_dl_q  <= '0;
      ch_dl_q  <= '0;
      code_q   <= '0;
      phase_q  <= 1'b0;
      idx_q    <= '0;
      period_q <= START_RST;
      thr_q    <= '0;
      boost_q  <= 1'b0;
      mute_q   <= 1'b0;
      busy_q   <= BUSY_W'(GAP_LAT);
    end else begin
      if (exec) begin
        mode_q   <= mode_d;
        ev_dl_q  <= ev_dl_d;
        ch_dl_q  <= ch_dl_d;
        code_q   <= code_d;
        phase_q  <= phase_d;
        idx_q    <= idx_d;
        period_q <= period_d;
        thr_q    <= thr_d;
        boost_q  <= boost_d;
        mute_q   <= mute_d;
      end
      if (cfg_i.wr || (exec && period_chg)) begin
        busy_q <= BUSY_W'(GAP_LAT);
      end else if (busy_q != '0) begin
        busy_q <= busy_q - 1'b1;
      end
    end
  end

  // result register: one word per executed request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (exec) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec) begin
      out_mode_q  <= mode_d;
      out_mask_q  <= thr_d;
      out_boost_q <= boost_d;
      out_mute_q  <= mute_d;
    end
  end

  assign rsp_o.valid          = out_valid_q;
  assign rsp_o.mode           = out_mode_q;
  assign rsp_o.thruster_mask  = out_mask_q;
  assign rsp_o.booster_on     = out_boost_q;
  assign rsp_o.joystick_muted = out_mute_q;

endmodule

[design/launch_sequencer_with_thruster_chaser.sv]
// Launch sequencer top level: front end, word queue and back end.
//
// Every request word (tick, escape, select, submit, advance) yields exactly one
// result word with the mode, thruster mask, booster and joystick mute after it.
// Unless a gap change or a result stall holds them, words flow at one per cycle
// through a two-entry queue and a registered result stage, so a word is taken
// while the previous result still waits. A tick that ends a chaser firing, or a
// submit that starts the countdown, changes the firing gap, and the back end holds
// the next word until the new gap is out of the shrink pipeline (multiply by
// percent, reciprocal divide by 100, floor); a configuration write restarts that
// pipeline too. The user must write configuration only while no word is in
// flight (not enforced); unused request codes return the current state unchanged.
module launch_sequencer_with_thruster_chaser import lsc_pkg::*; #(
  parameter int unsigned THRUSTER_COUNT = THRUSTER_COUNT_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  lsc_req_if.sink   req_i,
  lsc_rsp_if.source rsp_o,
  lsc_cfg_if.sink   cfg_i
);

  logic  q_push, q_full, q_pop, q_valid;
  item_t push_item, head_item;
  cfg_t  cfg;

  lsc_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (req_i),
    .cfg_i    (cfg_i),
    .q_full_i (q_full),
    .q_push_o (q_push),
    .item_o   (push_item),
    .cfg_o    (cfg)
  );

  lsc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (push_item),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .item_o  (head_item)
  );

  lsc_back #(
    .THRUSTER_COUNT (THRUSTER_COUNT)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .item_i    (head_item),
    .q_pop_o   (q_pop),
    .cfg_i     (cfg),
    .rsp_o     (rsp_o)
  );

endmodule

[design/lsc_checker.sv]
// Port-level checker for the launch sequencer, bound to the top level.
module lsc_checker import lsc_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_i,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input logic [MODE_W-1:0] mode_i,
  input logic [MASK_W-1:0] mask_i,
  input logic              booster_i,
  input logic              muted_i
);

  logic [2:0] pend_q;
  logic       in_acc, out_acc;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;

  // count words taken but not yet answered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_q + 3'(in_acc) - 3'(out_acc);
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable({mode_i, mask_i, booster_i, muted_i}))
    else $error("result word changed while stalled");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> pend_q != '0)
    else $error("result word without a request word");

  a_booster_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && booster_i |-> mode_i == MODE_LAUNCH)
    else $error("booster on outside launching mode");

  a_done_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && mode_i == MODE_DONE |-> mask_i == '0 && !muted_i && !booster_i)
    else $error("outputs active in complete mode");

endmodule

bind launch_sequencer_with_thruster_chaser lsc_checker u_lsc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (req_i.valid),
  .in_ready_i  (req_i.ready),
  .out_valid_i (rsp_o.valid),
  .out_ready_i (rsp_o.ready),
  .mode_i      (rsp_o.mode),
  .mask_i      (rsp_o.thruster_mask),
  .booster_i   (rsp_o.booster_on),
  .muted_i     (rsp_o.joystick_muted)
);

[tb/tb.sv]
// Testbench of the launch sequencer: random and directed event words checked against a predictor.
`timescale 1ns / 1ps

module tb import lsc_pkg::*; ();

  localparam int unsigned THRUSTERS       = THRUSTER_COUNT_DEF;
  localparam int unsigned PHASES          = 12;
  localparam int unsigned WORDS_PER_PHASE = 96;
  localparam int unsigned CYCLE_LIMIT     = 400000;
  localparam int unsigned SETTLE          = 16;
  localparam int unsigned PRINT_CAP       = 30;

  typedef struct packed {
    logic [REQ_W-1:0]  req;
    logic [TIME_W-1:0] now;
    logic [CODE_W-1:0] code;
    logic              frac;
  } word_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [MASK_W-1:0] mask;
    logic              boost;
    logic              mute;
  } status_t;

  // Tracks the sequencer state word by word and holds the status words still due.
  class launch_tracker;
    logic [TIME_W-1:0] cd_len, launch_len, wrong_len, lead_len;
    logic [GAP_W-1:0]  start_gap, floor_gap, on_len;
    logic [PCT_W-1:0]  pct;
    logic [MODE_W-1:0] mode;
    logic [TIME_W-1:0] event_dl, fire_dl;
    logic [CODE_W-1:0] code;
    logic              firing;
    int unsigned       idx;
    logic [GAP_W-1:0]  gap;
    logic [MASK_W-1:0] mask;
    logic              boost, mute;
    status_t           status_due[$];
    int unsigned       errors;

    function new();
      cd_len     = COUNTDOWN_RST;
      launch_len = LAUNCH_RST;
      wrong_len  = WRONG_RST;
      lead_len   = LEAD_RST;
      start_gap  = START_RST;
      floor_gap  = FLOOR_RST;
      on_len     = ON_RST;
      pct        = SPEEDUP_RST;
      mode       = MODE_HIDDEN;
      event_dl   = '0;
      fire_dl    = '0;
      code       = '0;
      firing     = 1'b0;
      idx        = 0;
      gap        = START_RST;
      mask       = '0;
      boost      = 1'b0;
      mute       = 1'b0;
      errors     = 0;
    endfunction

    function void set_reg(logic [CIDX_W-1:0] ridx, logic [TIME_W-1:0] data);
      case (ridx)
        CFG_COUNTDOWN: cd_len = data;
        CFG_LAUNCH:    launch_len = data;
        CFG_WRONG:     wrong_len = data;
        CFG_LEAD:      lead_len = data;
        CFG_START:     start_gap = data[GAP_W-1:0];
        CFG_FLOOR:     floor_gap = data[GAP_W-1:0];
        CFG_ON:        on_len = data[GAP_W-1:0];
        CFG_SPEEDUP:   pct = data[PCT_W-1:0];
        default: ;
      endcase
    endfunction

    // wrapping compare: t lies strictly after d within half the range
    function bit is_later(logic [TIME_W-1:0] t, logic [TIME_W-1:0] d);
      logic [TIME_W-1:0] diff;
      diff = t - d;
      return (diff != '0) && !diff[TIME_W-1];
    endfunction

    // thrusters above one share the top bit
    function logic [MASK_W-1:0] lamp(int unsigned n);
      return (n >= 2) ? 3'b100 : MASK_W'(1 << n);
    endfunction

    function void switch_mode(logic [MODE_W-1:0] m, logic [TIME_W-1:0] now);
      if (m == mode) return;
      boost = 1'b0;
      mode = m;
      case (m)
        MODE_HIDDEN: code = '0;
        MODE_WRONG:  event_dl = now + wrong_len;
        MODE_COUNT: begin
          event_dl = now + cd_len;
          firing = 1'b0;
          idx = 0;
          gap = start_gap;
          fire_dl = now + cd_len - lead_len;
        end
        MODE_LAUNCH: begin
          boost = 1'b1;
          event_dl = now + launch_len;
        end
        MODE_DONE: begin
          mask = '0;
          mute = 1'b0;
          boost = 1'b0;
        end
        default: ;
      endcase
    endfunction

    function void run_tick(logic [TIME_W-1:0] now);
      logic [63:0]      cut;
      logic [PCT_W-1:0] p;
      if ((mode == MODE_COUNT || mode == MODE_LAUNCH) && is_later(now, fire_dl)) begin
        mute = 1'b1;
        if (!firing) begin
          mask = mask | lamp(idx);
          firing = 1'b1;
          fire_dl = now + on_len;
        end else begin
          p = (pct > PCT_MAX) ? PCT_MAX : pct;
          mask = mask & ~lamp(idx);
          firing = 1'b0;
          idx = (idx + 1) % THRUSTERS;
          cut = (64'(gap) * 64'(p)) / 64'd100;
          gap = gap - cut[GAP_W-1:0];
          if (gap < floor_gap) gap = floor_gap;
          fire_dl = now + gap;
        end
      end
      if (!is_later(now, event_dl)) return;
      case (mode)
        MODE_WRONG:  switch_mode(MODE_ENTER, now);
        MODE_COUNT:  switch_mode(MODE_LAUNCH, now);
        MODE_LAUNCH: switch_mode(MODE_DONE, now);
        default: ;
      endcase
    endfunction

    // advance the state by one accepted word; returns 0 for an ignored select, submit or advance and for an unused code
    function bit note_request(word_t w);
      bit live;
      live = 1'b1;
      case (w.req)
        REQ_TICK:   run_tick(w.now);
        REQ_ESCAPE: switch_mode(MODE_HIDDEN, w.now);
        REQ_SELECT: begin
          if (mode == MODE_HIDDEN) begin
            code = w.code;
            switch_mode(MODE_ENTER, w.now);
          end else begin
            live = 1'b0;
          end
        end
        REQ_SUBMIT: begin
          if (mode == MODE_ENTER) begin
            if (w.code == code && !w.frac) switch_mode(MODE_COUNT, w.now);
            else switch_mode(MODE_WRONG, w.now);
          end else begin
            live = 1'b0;
          end
        end
        REQ_ADVANCE: begin
          if (mode == MODE_WRONG || mode == MODE_COUNT) event_dl = event_dl - ADVANCE_STEP_US;
          else live = 1'b0;
        end
        default: live = 1'b0;
      endcase
      status_due.push_back('{mode: mode, mask: mask, boost: boost, mute: mute});
      return live;
    endfunction

    task log_mismatch(string what);
      if (errors < PRINT_CAP) $display("mismatch: %s", what);
      errors++;
    endtask

    task check_status(status_t got);
      status_t want;
      if (status_due.size() == 0) begin
        log_mismatch($sformatf("status word %h with nothing due", got));
        return;
      end
      want = status_due.pop_front();
      if (got.mode != want.mode)
        log_mismatch($sformatf("mode got %0d want %0d", got.mode, want.mode));
      if (got.mask != want.mask)
        log_mismatch($sformatf("thruster_mask got %b want %b", got.mask, want.mask));
      if (got.boost != want.boost)
        log_mismatch($sformatf("booster_on got %b want %b", got.boost, want.boost));
      if (got.mute != want.mute)
        log_mismatch($sformatf("joystick_muted got %b want %b", got.mute, want.mute));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n;

  lsc_req_if req_if ();
  lsc_rsp_if rsp_if ();
  lsc_cfg_if cfg_if ();

  launch_tracker sb;

  int unsigned       send_idle_pct = 0;
  int unsigned       stall_pct = 0;
  int unsigned       tstep = 1;
  int unsigned       cycles = 0;
  logic [TIME_W-1:0] clock_us = '0;

  launch_sequencer_with_thruster_chaser dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .req_i (req_if),
    .rsp_o (rsp_if),
    .cfg_i (cfg_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(negedge clk) begin
    rsp_if.ready <= rst_n && ($urandom_range(0, 99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && rsp_if.valid && rsp_if.ready)
      sb.check_status(status_t'({rsp_if.mode, rsp_if.thruster_mask, rsp_if.booster_on,
                                 rsp_if.joystick_muted}));
  end

  function automatic word_t mk(logic [REQ_W-1:0] rq, logic [TIME_W-1:0] t,
                               logic [CODE_W-1:0] c, logic f);
    return '{req: rq, now: t, code: c, frac: f};
  endfunction

  // next word, shaped by the predicted mode so most sequences reach launch
  function automatic word_t draft_word();
    word_t       w;
    int unsigned r;
    bit          calm;
    r = $urandom_range(0, 99);
    calm = (sb.mode == MODE_COUNT || sb.mode == MODE_LAUNCH);
    // move the time cursor; far jumps only where no deadline is pending
    if ((sb.mode == MODE_HIDDEN || sb.mode == MODE_ENTER) && r < 2) clock_us = $urandom();
    else if (r < 7) clock_us = clock_us - $urandom_range(0, tstep);
    else if (r >= 11) clock_us = clock_us + $urandom_range(1, tstep);
    w.now = clock_us;
    w.code = CODE_W'($urandom());
    w.frac = 1'b0;
    w.req = REQ_TICK;
    r = $urandom_range(0, 99);
    if (r < (calm ? 3 : 8)) begin
      w.req = REQ_W'($urandom());
      w.now = $urandom();
      w.frac = 1'($urandom());
      return w;
    end
    r = $urandom_range(0, 99);
    case (sb.mode)
      MODE_HIDDEN: begin
        if (r < 75) w.req = REQ_SELECT;
        else if (r < 90) w.req = REQ_TICK;
        else w.req = REQ_ESCAPE;
        if ($urandom_range(0, 9) == 0) w.code = '0;
        else if ($urandom_range(0, 8) == 0) w.code = '1;
      end
      MODE_ENTER: begin
        if (r < 60) begin
          w.req = REQ_SUBMIT;
          w.code = sb.code;
        end else if (r < 80) begin
          w.req = REQ_SUBMIT;
          if ($urandom_range(0, 1)) begin
            w.code = sb.code;
            w.frac = 1'b1;
          end else begin
            w.frac = 1'($urandom());
          end
        end else if (r < 88) begin
          w.req = REQ_TICK;
        end else if (r < 94) begin
          w.req = REQ_SELECT;
        end else begin
          w.req = REQ_ESCAPE;
        end
      end
      MODE_WRONG: begin
        if (r < 70) w.req = REQ_TICK;
        else if (r < 88) w.req = REQ_ADVANCE;
        else if (r < 94) w.req = REQ_SUBMIT;
        else w.req = REQ_ESCAPE;
      end
      MODE_COUNT: begin
        if (r < 82) w.req = REQ_TICK;
        else if (r < 96) w.req = REQ_ADVANCE;
        else if (r < 98) w.req = REQ_SUBMIT;
        else if (r < 99) w.req = REQ_SELECT;
        else w.req = REQ_ESCAPE;
      end
      MODE_LAUNCH: begin
        if (r < 93) w.req = REQ_TICK;
        else if (r < 99) w.req = REQ_ADVANCE;
        else w.req = REQ_ESCAPE;
      end
      default: begin
        if (r < 45) w.req = REQ_ESCAPE;
        else if (r < 85) w.req = REQ_TICK;
        else w.req = REQ_ADVANCE;
      end
    endcase
    return w;
  endfunction

  // entered and left at a falling edge; valid stays high for a following word
  task automatic send_word(input word_t w, output bit live);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      @(negedge clk);
    end
    req_if.valid        <= 1'b1;
    req_if.req_type     <= w.req;
    req_if.now_us       <= w.now;
    req_if.entry_code   <= w.code;
    req_if.has_fraction <= w.frac;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    live = sb.note_request(w);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CIDX_W-1:0] ridx, input logic [TIME_W-1:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= ridx;
    cfg_if.data  <= data;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    sb.set_reg(ridx, data);
    @(negedge clk);
  endtask

  task automatic program_regs(input logic [TIME_W-1:0] cd, launch, wrong, lead,
                              input logic [TIME_W-1:0] start, floor, on, pct);
    write_reg(CFG_COUNTDOWN, cd);
    write_reg(CFG_LAUNCH, launch);
    write_reg(CFG_WRONG, wrong);
    write_reg(CFG_LEAD, lead);
    write_reg(CFG_START, start);
    write_reg(CFG_FLOOR, floor);
    write_reg(CFG_ON, on);
    write_reg(CFG_SPEEDUP, pct);
    cfg_if.valid <= 1'b0;
  endtask

  // hold off until every status word is back, then let the gap pipeline settle
  task automatic drain();
    req_if.valid <= 1'b0;
    while (sb.status_due.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  initial begin
    bit          live;
    bit          paused;
    int unsigned done_words;
    int unsigned scale;
    sb = new();
    rst_n               = 1'b0;
    req_if.valid        = 1'b0;
    req_if.req_type     = REQ_TICK;
    req_if.now_us       = '0;
    req_if.entry_code   = '0;
    req_if.has_fraction = 1'b0;
    rsp_if.ready        = 1'b0;
    cfg_if.valid        = 1'b0;
    cfg_if.index        = CFG_COUNTDOWN;
    cfg_if.data         = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    repeat (2) @(negedge clk);

    // directed: ignored words, wrong code and back, chaser firing, escape keeping thrusters
    send_word(mk(REQ_TICK, 32'd0, 14'd0, 1'b0), live);
    send_word(mk(REQ_SUBMIT, 32'd0, 14'h3FFF, 1'b1), live);
    send_word(mk(REQ_ADVANCE, 32'd1, 14'd0, 1'b0), live);
    send_word(mk(REQ_RSVD5, 32'hFFFF_FFFF, 14'h3FFF, 1'b1), live);
    send_word(mk(REQ_RSVD6, 32'hFFFF_FFFF, 14'h3FFF, 1'b1), live);
    send_word(mk(REQ_RSVD7, 32'd5, 14'd0, 1'b0), live);
    send_word(mk(REQ_ESCAPE, 32'd6, 14'd0, 1'b0), live);
    send_word(mk(REQ_SELECT, 32'd100, 14'h3FFF, 1'b0), live);
    send_word(mk(REQ_SELECT, 32'd101, 14'd0, 1'b0), live);
    send_word(mk(REQ_SUBMIT, 32'd102, 14'h3FFF, 1'b1), live);
    repeat (3) send_word(mk(REQ_ADVANCE, 32'd103, 14'd0, 1'b0), live);
    send_word(mk(REQ_TICK, 32'd102, 14'd0, 1'b0), live);
    send_word(mk(REQ_TICK, 32'd103, 14'd0, 1'b0), live);
    send_word(mk(REQ_SUBMIT, 32'd200, 14'h3FFF, 1'b0), live);
    send_word(mk(REQ_TICK, 32'd2147483648 + 32'd14000200, 14'd0, 1'b0), live);
    send_word(mk(REQ_ADVANCE, 32'd300, 14'd0, 1'b0), live);
    send_word(mk(REQ_TICK, 32'd14000201, 14'd0, 1'b0), live);
    send_word(mk(REQ_TICK, 32'd14150202, 14'd0, 1'b0), live);
    send_word(mk(REQ_TICK, 32'd14810203, 14'd0, 1'b0), live);
    send_word(mk(REQ_ESCAPE, 32'd14810300, 14'd0, 1'b0), live);
    send_word(mk(REQ_SELECT, 32'd14810400, 14'd0, 1'b0), live);
    send_word(mk(REQ_SUBMIT, 32'd14810500, 14'd0, 1'b0), live);
    send_word(mk(REQ_TICK, 32'hFFFF_FFFF, 14'd0, 1'b0), live);
    send_word(mk(REQ_TICK, 32'd35310501, 14'd0, 1'b0), live);
    send_word(mk(REQ_TICK, 32'd45310502, 14'd0, 1'b0), live);
    send_word(mk(REQ_ESCAPE, 32'd45310600, 14'd0, 1'b0), live);
    clock_us = 32'd45310600;

    for (int unsigned phase = 0; phase < PHASES; phase++) begin
      drain();
      case (phase)
        0: tstep = 800000;
        1: begin
          program_regs(32'd2000, 32'd1500, 32'd300, 32'd1500, 32'd200, 32'd20, 32'd50, 32'd25);
          tstep = 160;
        end
        2: begin
          program_regs(32'd0, 32'd0, 32'd0, 32'd0, 32'd1, 32'd1, 32'd1, 32'd0);
          tstep = 2;
        end
        3: begin
          program_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                       32'hF_FFFF, 32'hF_FFFF, 32'hF_FFFF, 32'd100);
          tstep = 300000;
        end
        4: begin
          // percent above the maximum drops the gap straight to the floor
          program_regs(32'd3000, 32'd2000, 32'd500, 32'd2500, 32'hF_FFFF, 32'd7, 32'd40, 32'd127);
          tstep = 120;
        end
        5: begin
          program_regs(32'd4000, 32'd3000, 32'd800, 32'd3500, 32'd900, 32'd900, 32'd25, 32'd101);
          tstep = 150;
        end
        11: begin
          // lead beyond the countdown: first firing lands in the past
          program_regs(32'd1000, 32'd4000, 32'h7FFF_FFFF, 32'd3000, 32'd300, 32'd50, 32'd60,
                       32'd50);
          tstep = 100;
        end
        default: begin
          scale = 1 << $urandom_range(3, 16);
          program_regs(($urandom_range(0, 9) == 0) ? $urandom() : $urandom_range(0, 20 * scale),
                       $urandom_range(0, 10 * scale), $urandom_range(0, 4 * scale),
                       $urandom_range(0, 20 * scale), $urandom_range(1, 2 * scale),
                       $urandom_range(1, scale), $urandom_range(1, scale),
                       $urandom_range(0, 127));
          tstep = scale / 2 + 1;
        end
      endcase
      case (phase % 4)
        0: begin
          send_idle_pct = 0;
          stall_pct = 0;
        end
        1: begin
          send_idle_pct = 56;
          stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct = 56;
        end
        default: begin
          send_idle_pct = 38;
          stall_pct = 38;
        end
      endcase
      // start near the wrap point half the time
      if ($urandom_range(0, 1)) clock_us = 32'hFFFF_FFFF - $urandom_range(0, tstep * 40);
      done_words = 0;
      paused = 1'b0;
      while (done_words < WORDS_PER_PHASE) begin
        if (done_words == WORDS_PER_PHASE / 2 && !paused) begin
          drain();
          paused = 1'b1;
        end
        send_word(draft_word(), live);
        if (live) done_words++;
      end
    end

    drain();
    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
